// ===== rtl/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

   localparam int FUNC_W   = 3;
   localparam int SIZE_W   = 19;
   localparam int PAGE_W   = 10;
   localparam int STATUS_W = 2;

   localparam logic [SIZE_W-1:0] BYTES_MAX = '1;

   // Page map entry encodings
   localparam logic [1:0] MAP_FREE = 2'b00;
   localparam logic [1:0] MAP_USED = 2'b01;
   localparam logic [1:0] MAP_END  = 2'b11;

   typedef enum logic [FUNC_W-1:0] {
      FN_ALLOC      = 3'd0,
      FN_FREE       = 3'd1,
      FN_SIZE       = 3'd2,
      FN_FREE_SPACE = 3'd3,
      FN_USED_SPACE = 3'd4
   } pba_func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_MEMORY = 2'd1,
      STAT_BAD_CHAIN = 2'd2
   } pba_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_FILL,
      ST_WALK,
      ST_FINISH
   } pba_state_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_CLEAR,
      DP_SCAN,
      DP_FILL,
      DP_WALK
   } pba_op_type;

   typedef enum logic [2:0] {
      RK_OK_ZERO,
      RK_NO_MEMORY,
      RK_BAD_CHAIN,
      RK_ALLOC,
      RK_SIZE,
      RK_FREE_SPACE,
      RK_USED_SPACE
   } pba_kind_type;

   typedef struct packed {
      pba_op_type   op;
      logic         load;
      logic         rsp_load;
      pba_kind_type rsp_kind;
   } pba_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              size_zero;
      logic              start_ok;
      logic              clear_last;
      logic              scan_hit;
      logic              scan_miss;
      logic              fill_last;
      logic              walk_end;
      logic              walk_bad;
   } pba_sts_type;

endpackage

// ===== rtl/page_bitmap_allocator_core.sv =====
// Allocate reads one page per cycle through the single page map read port, then makes
//   one write per page of the run. One request at a time; a new request is taken while
//   the previous result waits in the output register.
// Reset: synchronous; a clearing pass then zeroes the page map with req_ready low.
module page_bitmap_allocator_core import pba_pkg::*; #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [PAGE_W-1:0]   req_page_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_result_page,
   output logic [SIZE_W-1:0]   rsp_byte_count
);

   pba_cmd_type cmd;
   pba_sts_type sts;

   pba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pba_datapath #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_size_bytes  (req_size_bytes),
      .req_page_index  (req_page_index),
      .rsp_status      (rsp_status),
      .rsp_result_page (rsp_result_page),
      .rsp_byte_count  (rsp_byte_count)
   );

endmodule

// ===== rtl/pba_datapath.sv =====
// Page map memory, scan and walk pointers, usage counter and result registers.
module pba_datapath import pba_pkg::*; #(
   parameter int NUM_PAGES  = 1024,
   parameter int PAGE_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  pba_cmd_type         cmd,
   output pba_sts_type         sts,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SIZE_W-1:0]   req_size_bytes,
   input  logic [PAGE_W-1:0]   req_page_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PAGE_W-1:0]   rsp_result_page,
   output logic [SIZE_W-1:0]   rsp_byte_count
);

   localparam int PW  = $clog2(NUM_PAGES);
   localparam int CW  = $clog2(NUM_PAGES + 1);
   localparam int RBW = SIZE_W + 1;
   localparam logic [PW-1:0]  TOP  = PW'(NUM_PAGES - 1);
   localparam logic [RBW-1:0] PB_R = RBW'(PAGE_BYTES);

   logic [1:0] mem [NUM_PAGES];

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                start_ok_ff, start_ok_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic                stop_ff, stop_in;
   logic                rvld_ff, rvld_in;
   logic [PW-1:0]       raddr_ff, raddr_in;
   logic [1:0]          rdata_ff;
   logic [CW-1:0]       run_ff, run_in;
   logic [RBW-1:0]      runb_ff, runb_in;
   logic [CW-1:0]       n_ff, n_in;
   logic [PW-1:0]       base_ff, base_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [SIZE_W-1:0]   rsp_bytes_ff, rsp_bytes_in;

   logic          mem_we, mem_re;
   logic [PW-1:0] mem_waddr;
   logic [1:0]    mem_wdata;
   logic          scan_hit, walk_end;
   logic [CW-1:0] cnt_sel;
   logic [31:0]   prod;

   assign scan_hit = rvld_ff && !rdata_ff[0] && ((runb_ff + PB_R) >= RBW'(size_ff));
   assign walk_end = rvld_ff && (rdata_ff == MAP_END);

   always_comb begin
      func_in     = func_ff;
      size_in     = size_ff;
      start_ok_in = start_ok_ff;
      ptr_in      = ptr_ff;
      stop_in     = stop_ff;
      rvld_in     = 1'b0;
      raddr_in    = raddr_ff;
      run_in      = run_ff;
      runb_in     = runb_ff;
      n_in        = n_ff;
      base_in     = base_ff;
      used_in     = used_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = ptr_ff;
      mem_wdata   = MAP_FREE;

      if (cmd.load) begin
         func_in     = req_func;
         size_in     = req_size_bytes;
         start_ok_in = 32'(req_page_index) < NUM_PAGES;
         ptr_in      = (req_func == FN_ALLOC) ? TOP : PW'(req_page_index);
         stop_in     = 1'b0;
         run_in      = '0;
         runb_in     = '0;
         n_in        = '0;
      end

      case (cmd.op)
         DP_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end
         DP_SCAN: begin
            // Issue reads downward, evaluate the page read last cycle
            if (!stop_ff) begin
               mem_re   = 1'b1;
               rvld_in  = 1'b1;
               raddr_in = ptr_ff;
               if (ptr_ff == '0) stop_in = 1'b1;
               else ptr_in = ptr_ff - 1'b1;
            end
            if (rvld_ff) begin
               if (rdata_ff[0]) begin
                  run_in  = '0;
                  runb_in = '0;
               end else begin
                  run_in  = run_ff + 1'b1;
                  runb_in = runb_ff + PB_R;
               end
               if (scan_hit) begin
                  ptr_in  = raddr_ff;
                  base_in = raddr_ff;
                  n_in    = run_ff + 1'b1;
                  used_in = used_ff + run_ff + CW'(1);
               end
            end
         end
         DP_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = (run_ff == CW'(1)) ? MAP_END : MAP_USED;
            ptr_in    = ptr_ff + 1'b1;
            run_in    = run_ff - 1'b1;
         end
         DP_WALK: begin
            if (!stop_ff) begin
               mem_re   = 1'b1;
               rvld_in  = 1'b1;
               raddr_in = ptr_ff;
               if (ptr_ff == TOP) stop_in = 1'b1;
               else ptr_in = ptr_ff + 1'b1;
            end
            if (rvld_ff) begin
               n_in = n_ff + 1'b1;
               if (func_ff == FN_FREE) begin
                  mem_we    = 1'b1;
                  mem_waddr = raddr_ff;
                  if (rdata_ff[0]) used_in = used_ff - 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.rsp_kind)
         RK_ALLOC, RK_SIZE: cnt_sel = n_ff;
         RK_FREE_SPACE:     cnt_sel = CW'(NUM_PAGES) - used_ff;
         RK_USED_SPACE:     cnt_sel = used_ff;
         default:           cnt_sel = '0;
      endcase
      prod = 32'(cnt_sel) * 32'(PAGE_BYTES);
      rsp_bytes_in = (prod > 32'(BYTES_MAX)) ? BYTES_MAX : prod[SIZE_W-1:0];
      rsp_page_in  = (cmd.rsp_kind == RK_ALLOC) ? PAGE_W'(base_ff) : '0;
      case (cmd.rsp_kind)
         RK_NO_MEMORY: rsp_status_in = STAT_NO_MEMORY;
         RK_BAD_CHAIN: rsp_status_in = STAT_BAD_CHAIN;
         default:      rsp_status_in = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         stop_ff <= 1'b0;
         rvld_ff <= 1'b0;
         used_ff <= '0;
      end else begin
         ptr_ff  <= ptr_in;
         stop_ff <= stop_in;
         rvld_ff <= rvld_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      size_ff     <= size_in;
      start_ok_ff <= start_ok_in;
      raddr_ff    <= raddr_in;
      run_ff      <= run_in;
      runb_ff     <= runb_in;
      n_ff        <= n_in;
      base_ff     <= base_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_page_ff   <= rsp_page_in;
         rsp_bytes_ff  <= rsp_bytes_in;
      end
   end

   always_comb begin
      sts.func       = func_ff;
      sts.size_zero  = (size_ff == '0);
      sts.start_ok   = start_ok_ff;
      sts.clear_last = (ptr_ff == TOP);
      sts.scan_hit   = scan_hit;
      sts.scan_miss  = rvld_ff && !scan_hit && (raddr_ff == '0);
      sts.fill_last  = (run_ff == CW'(1));
      sts.walk_end   = walk_end;
      sts.walk_bad   = rvld_ff && !walk_end && (raddr_ff == TOP);
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_byte_count  = rsp_bytes_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= NUM_PAGES)
      else $error("used page count exceeds map size");

   a_fill_in_map: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_FILL) |-> (ptr_ff <= TOP) && (run_ff != '0))
      else $error("fill runs past the map or with no pages left");

endmodule

// ===== rtl/pba_ctrl.sv =====
// Sequencer for the page bitmap allocator: clearing pass, scan, fill, walk, result hand-off.
module pba_ctrl import pba_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output pba_cmd_type cmd,
   input  pba_sts_type sts
);

   pba_state_type state_ff, state_in;
   pba_kind_type  kind_ff, kind_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          finish_go;

   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_FINISH;
            case (sts.func) inside
               FN_ALLOC: begin
                  if (sts.size_zero) kind_in = RK_NO_MEMORY;
                  else state_in = ST_SCAN;
               end
               FN_FREE, FN_SIZE: begin
                  if (sts.start_ok) state_in = ST_WALK;
                  else kind_in = RK_OK_ZERO;
               end
               FN_FREE_SPACE: kind_in = RK_FREE_SPACE;
               FN_USED_SPACE: kind_in = RK_USED_SPACE;
               default:       kind_in = RK_OK_ZERO;
            endcase
         end
         ST_SCAN: begin
            if (sts.scan_hit) begin
               state_in = ST_FILL;
            end else if (sts.scan_miss) begin
               state_in = ST_FINISH;
               kind_in  = RK_NO_MEMORY;
            end
         end
         ST_FILL: begin
            if (sts.fill_last) begin
               state_in = ST_FINISH;
               kind_in  = RK_ALLOC;
            end
         end
         ST_WALK: begin
            if (sts.walk_end) begin
               state_in = ST_FINISH;
               kind_in  = (sts.func == FN_SIZE) ? RK_SIZE : RK_OK_ZERO;
            end else if (sts.walk_bad) begin
               state_in = ST_FINISH;
               kind_in  = RK_BAD_CHAIN;
            end
         end
         ST_FINISH: begin
            if (finish_go) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = DP_NOP;
      cmd.load     = 1'b0;
      cmd.rsp_load = 1'b0;
      cmd.rsp_kind = kind_ff;
      unique case (state_ff)
         ST_CLEAR: cmd.op = DP_CLEAR;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DISPATCH: ;
         ST_SCAN:     cmd.op = DP_SCAN;
         ST_FILL:     cmd.op = DP_FILL;
         ST_WALK:     cmd.op = DP_WALK;
         ST_FINISH:   cmd.rsp_load = finish_go;
         default: ;
      endcase
   end

   // Set on a new result, drop when the old one is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_go) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         kind_ff      <= RK_OK_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request not dispatched");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("loaded result not presented");

   a_fill_after_scan: assert property (@(posedge clock) disable iff (reset)
      ($rose(state_ff == ST_FILL)) |-> ($past(state_ff) == ST_SCAN) && $past(sts.scan_hit))
      else $error("fill entered without a fitting run");

endmodule

// ===== verif/page_bitmap_allocator_core_test.sv =====
// Self-checking testbench for the page bitmap allocator core.
`timescale 1ns / 100ps

module page_bitmap_allocator_core_test;
   import pba_pkg::*;

   localparam int NUM_PAGES  = 1024;
   localparam int PAGE_BYTES = 256;
   localparam int RANDOM_REQUESTS = 560;
   localparam int TAIL_CYCLES = 2200;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [SIZE_W-1:0] size;
      logic [PAGE_W-1:0] page;
   } heap_request_t;

   typedef struct packed {
      pba_status_type    status;
      logic [PAGE_W-1:0] page;
      logic [SIZE_W-1:0] bytes;
   } heap_answer_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [SIZE_W-1:0]   req_size_bytes = '0;
   logic [PAGE_W-1:0]   req_page_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [PAGE_W-1:0]   rsp_result_page;
   logic [SIZE_W-1:0]   rsp_byte_count;

   logic [1:0]    heap_map [NUM_PAGES];
   heap_request_t pending_requests [$];
   heap_answer_t  heap_answers [$];
   logic          req_taken = 1'b0;
   logic          quiet_tail = 1'b0;
   int            issued_count = 0;
   int            accepted_count = 0;
   int            error_count = 0;
   int            send_gap = 0;
   int            stall_left = 0;

   page_bitmap_allocator_core #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_size_bytes  (req_size_bytes),
      .req_page_index  (req_page_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_page (rsp_result_page),
      .rsp_byte_count  (rsp_byte_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [SIZE_W-1:0] page_bytes(input int pages);
      longint b;
      b = longint'(pages) * PAGE_BYTES;
      return (b > BYTES_MAX) ? BYTES_MAX : b[SIZE_W-1:0];
   endfunction

   function automatic int used_pages();
      int n;
      n = 0;
      for (int p = 0; p < NUM_PAGES; p++)
         if (heap_map[p][0]) n++;
      return n;
   endfunction

   // Apply one request to the shadow page map and return its answer.
   function automatic heap_answer_t heap_predict(input heap_request_t r);
      heap_answer_t a;
      int need, run, p, n;
      bit found, ended;
      logic [1:0] bits;
      a.status = STAT_OK;
      a.page   = '0;
      a.bytes  = '0;
      case (r.func)
         FN_ALLOC: begin
            need = (int'(r.size) + PAGE_BYTES - 1) / PAGE_BYTES;
            a.status = STAT_NO_MEMORY;
            found = 1'b0;
            run = 0;
            p = NUM_PAGES;
            // first fit, scanning from the top page down
            if (need != 0) begin
               while (p > 0 && !found) begin
                  p--;
                  if (heap_map[p][0]) begin
                     run = 0;
                  end else begin
                     run++;
                     if (run == need) found = 1'b1;
                  end
               end
            end
            if (found) begin
               for (int k = 0; k < need; k++) heap_map[p + k] = MAP_USED;
               heap_map[p + need - 1] = MAP_END;
               a.status = STAT_OK;
               a.page   = p[PAGE_W-1:0];
               a.bytes  = page_bytes(need);
            end
         end
         FN_FREE, FN_SIZE: begin
            if (int'(r.page) < NUM_PAGES) begin
               p = r.page;
               n = 0;
               ended = 1'b0;
               while (p < NUM_PAGES && !ended) begin
                  bits = heap_map[p];
                  if (r.func == FN_FREE) heap_map[p] = MAP_FREE;
                  n++;
                  p++;
                  if (bits == MAP_END) ended = 1'b1;
               end
               if (!ended) a.status = STAT_BAD_CHAIN;
               else if (r.func == FN_SIZE) a.bytes = page_bytes(n);
            end
         end
         FN_FREE_SPACE: a.bytes = page_bytes(NUM_PAGES - used_pages());
         FN_USED_SPACE: a.bytes = page_bytes(used_pages());
         default: ;
      endcase
      return a;
   endfunction

   task automatic queue_request(input logic [FUNC_W-1:0] func, input int size, input int page);
      heap_request_t r;
      r.func = func;
      r.size = size[SIZE_W-1:0];
      r.page = page[PAGE_W-1:0];
      pending_requests.push_back(r);
      issued_count++;
   endtask

   task automatic wait_accepted();
      while (accepted_count != issued_count) @(negedge clock);
   endtask

   // Build a short burst of requests against the current heap contents.
   task automatic queue_random_batch(input int count);
      int live [$];
      int sel, idx, size, page;
      logic [FUNC_W-1:0] func;
      for (int p = 0; p < NUM_PAGES; p++)
         if (heap_map[p][0] && (p == 0 || !heap_map[p-1][0] || heap_map[p-1] == MAP_END))
            live.push_back(p);
      for (int i = 0; i < count; i++) begin
         size = $urandom_range(0, 524287);
         page = $urandom_range(0, NUM_PAGES - 1);
         sel = $urandom_range(0, 99);
         if (sel < 38) func = FN_ALLOC;
         else if (sel < 62) func = FN_FREE;
         else if (sel < 76) func = FN_SIZE;
         else if (sel < 85) func = FN_FREE_SPACE;
         else if (sel < 94) func = FN_USED_SPACE;
         else func = $urandom_range(5, 7);
         if (func == FN_ALLOC) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) size = $urandom_range(1, 2048);
            else if (sel < 88) size = $urandom_range(2049, 32768);
            else if (sel < 97) size = $urandom_range(32769, NUM_PAGES * PAGE_BYTES);
            else if (sel < 99) size = $urandom_range(NUM_PAGES * PAGE_BYTES + 1, 524287);
            else size = 0;
         end else if ((func == FN_FREE || func == FN_SIZE) && live.size() > 0
                      && $urandom_range(0, 99) < 85) begin
            idx = $urandom_range(0, live.size() - 1);
            page = live[idx];
            live.delete(idx);
         end
         queue_request(func, size, page);
      end
   endtask

   // Request driver
   always @(negedge clock) begin : drive_requests
      heap_request_t r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (req_valid && !quiet_tail && $urandom_range(0, 5) == 0) begin
            send_gap  <= $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_func       <= r.func;
            req_size_bytes <= r.size;
            req_page_index <= r.page;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict on every accepted request
   always @(posedge clock) begin : take_requests
      heap_request_t r;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         r.func = req_func;
         r.size = req_size_bytes;
         r.page = req_page_index;
         heap_answers.push_back(heap_predict(r));
         accepted_count <= accepted_count + 1;
      end
   end

   // Result monitor
   always @(posedge clock) begin : check_results
      heap_answer_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (heap_answers.size() == 0) begin
            $display("%0t: unexpected result status %0d result_page %0d byte_count %0d",
                     $time, rsp_status, rsp_result_page, rsp_byte_count);
            error_count++;
         end else begin
            want = heap_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_result_page !== want.page) begin
               $display("%0t: result_page expected %0d got %0d",
                        $time, want.page, rsp_result_page);
               error_count++;
            end
            if (rsp_byte_count !== want.bytes) begin
               $display("%0t: byte_count expected %0d got %0d",
                        $time, want.bytes, rsp_byte_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      int sent;
      int burst;
      for (int p = 0; p < NUM_PAGES; p++) heap_map[p] = MAP_FREE;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // empty heap: totals, chain walks that never find an end
      queue_request(FN_FREE_SPACE, 0, 0);
      queue_request(FN_USED_SPACE, 524287, 1023);
      queue_request(FN_SIZE, 0, 0);
      queue_request(FN_FREE, 0, 1023);
      // zero size, oversize, then the whole heap at once
      queue_request(FN_ALLOC, 0, 0);
      queue_request(FN_ALLOC, 524287, 1023);
      queue_request(FN_ALLOC, NUM_PAGES * PAGE_BYTES, 0);
      queue_request(FN_USED_SPACE, 0, 0);
      queue_request(FN_ALLOC, 1, 0);
      queue_request(FN_SIZE, 0, 0);
      queue_request(FN_FREE, 0, 0);
      // rounding to pages near the top of the map
      queue_request(FN_ALLOC, 1, 0);
      queue_request(FN_ALLOC, PAGE_BYTES, 0);
      queue_request(FN_ALLOC, PAGE_BYTES + 1, 0);
      queue_request(FN_SIZE, 0, 1020);
      // free the tail of a run, so the chain runs on into its neighbor
      queue_request(FN_FREE, 0, 1021);
      queue_request(FN_SIZE, 0, 1020);
      queue_request(5, 524287, 1023);
      queue_request(6, 0, 0);
      queue_request(7, 524287, 1023);
      queue_request(FN_FREE, 0, 1020);
      queue_request(FN_FREE, 0, 1023);
      queue_request(FN_FREE_SPACE, 0, 0);
      wait_accepted();

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 6);
         queue_random_batch(burst);
         sent += burst;
         if (sent > RANDOM_REQUESTS - 80) quiet_tail = 1'b1;
         wait_accepted();
      end

      while (heap_answers.size() > 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== page_bitmap_allocator_core.f =====
rtl/pba_pkg.sv
rtl/pba_datapath.sv
rtl/pba_ctrl.sv
rtl/page_bitmap_allocator_core.sv
verif/page_bitmap_allocator_core_test.sv
